// ----- rtl/rpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and helpers for the rectangle polygon clipper
// Coordinate formats, the token passed between clip cells and the cell setup.
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int CW       = 16;            // coordinate width, signed Q12.4
  localparam int MW       = CW;            // magnitude width of a difference
  localparam int PW       = 2 * MW;        // product width
  localparam int CNT_W    = $clog2(PW + 1);
  localparam int AW       = 4;             // APB address width
  localparam int DW       = 32;            // APB data width

  // register indexes
  localparam logic [1:0] REG_X_MIN = 2'd0;
  localparam logic [1:0] REG_Y_MIN = 2'd1;
  localparam logic [1:0] REG_X_MAX = 2'd2;
  localparam logic [1:0] REG_Y_MAX = 2'd3;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  // token on the cell chain: a vertex, or the end-of-polygon marker
  typedef struct packed {
    pt_t  pt;
    logic cls;
  } tok_t;

  // per-cell window edge setup
  typedef struct packed {
    logic   axis_y;   // edge tests y (horizontal edge)
    logic   keep_gt;  // inside when coordinate is above the edge
    coord_t edge_v;
  } cell_cfg_t;

  // coordinate tested against the edge
  function automatic coord_t get_u(pt_t p, logic axis_y);
    return axis_y ? p.y : p.x;
  endfunction

  // the other coordinate
  function automatic coord_t get_v(pt_t p, logic axis_y);
    return axis_y ? p.x : p.y;
  endfunction

  // strict inside test
  function automatic logic is_inside(pt_t p, cell_cfg_t c);
    coord_t u;
    u = get_u(p, c.axis_y);
    return c.keep_gt ? (u > c.edge_v) : (u < c.edge_v);
  endfunction

  // magnitude of a 17-bit signed difference
  function automatic logic [MW-1:0] mag(logic signed [CW:0] d);
    logic signed [CW:0] n;
    n = -d;
    return d[CW] ? n[MW-1:0] : d[MW-1:0];
  endfunction

endpackage

// ----- rtl/rpc_if.sv -----
// ----------------------------------------------------------------------------
// rpc_in_if / rpc_out_if: valid/ready channels of the clipper
// Vertex channel in, clipped vertex channel out.
// ----------------------------------------------------------------------------
interface rpc_in_if;
  logic                        valid;
  logic                        ready;
  logic signed [rpc_pkg::CW-1:0] vertex_x;
  logic signed [rpc_pkg::CW-1:0] vertex_y;
  logic                        vertex_last;

  modport source (output valid, vertex_x, vertex_y, vertex_last, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_last, output ready);
endinterface

interface rpc_out_if;
  logic                        valid;
  logic                        ready;
  logic signed [rpc_pkg::CW-1:0] out_x;
  logic signed [rpc_pkg::CW-1:0] out_y;
  logic                        out_last;
  logic                        out_empty;

  modport source (output valid, out_x, out_y, out_last, out_empty, input ready);
  modport sink   (input valid, out_x, out_y, out_last, out_empty, output ready);
endinterface

// ----- rtl/rpc_cell.sv -----
// ----------------------------------------------------------------------------
// rpc_cell: one clip stage of the chain
// Tests each vertex pair against one window edge, computes the crossing with
// a registered multiply and a bit-serial divide, and passes tokens onward.
// ----------------------------------------------------------------------------
module rpc_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  rpc_pkg::cell_cfg_t cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  rpc_pkg::tok_t      in_tok,
  output logic               out_valid,
  input  logic               out_ready,
  output rpc_pkg::tok_t      out_tok
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  rpc_pkg::pt_t                first_r, first_nxt;
  rpc_pkg::pt_t                prev_r, prev_nxt;
  logic                        started_r, started_nxt;
  rpc_pkg::pt_t                s_r, s_nxt;
  rpc_pkg::pt_t                e_r, e_nxt;
  logic                        need_x_r, need_x_nxt;
  logic                        need_e_r, need_e_nxt;
  logic                        need_cls_r, need_cls_nxt;
  logic [rpc_pkg::MW-1:0]      a_r, a_nxt;
  logic [rpc_pkg::MW-1:0]      b_r, b_nxt;
  logic [rpc_pkg::MW-1:0]      c_r, c_nxt;
  logic                        neg_r, neg_nxt;
  logic [rpc_pkg::PW-1:0]      dvd_r, dvd_nxt;
  logic [rpc_pkg::MW-1:0]      rem_r, rem_nxt;
  logic [rpc_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        ovalid_r, ovalid_nxt;
  rpc_pkg::tok_t               otok_r, otok_nxt;

  // pair selection and edge differences
  rpc_pkg::pt_t                ps, pe;
  rpc_pkg::coord_t             ps_u, ps_v, pe_u, pe_v, s_v;
  logic                        pair_on, si, ei;
  logic signed [rpc_pkg::CW:0] da, db, dc;
  logic [rpc_pkg::MW:0]        trial;
  logic                        slot_free;
  logic signed [rpc_pkg::CW:0] qs, vsum;
  rpc_pkg::pt_t                xpt;

  assign in_ready  = (state_r == ST_IDLE);
  assign slot_free = !ovalid_r || out_ready;
  assign out_valid = ovalid_r;
  assign out_tok   = otok_r;

  always_comb begin
    ps      = prev_r;
    pe      = in_tok.cls ? first_r : in_tok.pt;
    pair_on = started_r;
    si      = rpc_pkg::is_inside(ps, cfg);
    ei      = rpc_pkg::is_inside(pe, cfg);
    ps_u    = rpc_pkg::get_u(ps, cfg.axis_y);
    ps_v    = rpc_pkg::get_v(ps, cfg.axis_y);
    pe_u    = rpc_pkg::get_u(pe, cfg.axis_y);
    pe_v    = rpc_pkg::get_v(pe, cfg.axis_y);
    da = {pe_v[rpc_pkg::CW-1], pe_v} - {ps_v[rpc_pkg::CW-1], ps_v};
    db = {cfg.edge_v[rpc_pkg::CW-1], cfg.edge_v} - {ps_u[rpc_pkg::CW-1], ps_u};
    dc = {pe_u[rpc_pkg::CW-1], pe_u} - {ps_u[rpc_pkg::CW-1], ps_u};
  end

  // crossing point from the quotient
  always_comb begin
    qs   = neg_r ? -$signed({1'b0, dvd_r[rpc_pkg::MW-1:0]})
                 : $signed({1'b0, dvd_r[rpc_pkg::MW-1:0]});
    s_v  = rpc_pkg::get_v(s_r, cfg.axis_y);
    vsum = {s_v[rpc_pkg::CW-1], s_v} + qs;
    if (cfg.axis_y) begin
      xpt.x = vsum[rpc_pkg::CW-1:0];
      xpt.y = cfg.edge_v;
    end else begin
      xpt.x = cfg.edge_v;
      xpt.y = vsum[rpc_pkg::CW-1:0];
    end
  end

  assign trial = {rem_r, dvd_r[rpc_pkg::PW-1]};

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    first_nxt    = first_r;
    prev_nxt     = prev_r;
    started_nxt  = started_r;
    s_nxt        = s_r;
    e_nxt        = e_r;
    need_x_nxt   = need_x_r;
    need_e_nxt   = need_e_r;
    need_cls_nxt = need_cls_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    c_nxt        = c_r;
    neg_nxt      = neg_r;
    dvd_nxt      = dvd_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    ovalid_nxt   = ovalid_r && !out_ready;
    otok_nxt     = otok_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_tok.cls) begin
            started_nxt = 1'b0;
          end else if (!started_r) begin
            first_nxt   = in_tok.pt;
            prev_nxt    = in_tok.pt;
            started_nxt = 1'b1;
          end else begin
            prev_nxt = in_tok.pt;
          end
          s_nxt        = ps;
          e_nxt        = pe;
          need_x_nxt   = pair_on && (si != ei);
          need_e_nxt   = pair_on && ei;
          need_cls_nxt = in_tok.cls;
          a_nxt        = rpc_pkg::mag(da);
          b_nxt        = rpc_pkg::mag(db);
          c_nxt        = rpc_pkg::mag(dc);
          neg_nxt      = da[rpc_pkg::CW] ^ db[rpc_pkg::CW] ^ dc[rpc_pkg::CW];
          if (pair_on && (si != ei)) begin
            state_nxt = ST_MUL;
          end else if ((pair_on && ei) || in_tok.cls) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_MUL: begin
        dvd_nxt   = a_r * b_r;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // one quotient bit per cycle
        if (trial >= {1'b0, c_r}) begin
          rem_nxt = rpc_pkg::MW'(trial - {1'b0, c_r});
          dvd_nxt = {dvd_r[rpc_pkg::PW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[rpc_pkg::MW-1:0];
          dvd_nxt = {dvd_r[rpc_pkg::PW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == rpc_pkg::CNT_W'(rpc_pkg::PW - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          if (need_x_r) begin
            otok_nxt   = '{pt: xpt, cls: 1'b0};
            need_x_nxt = 1'b0;
            if (!need_e_r && !need_cls_r) state_nxt = ST_IDLE;
          end else if (need_e_r) begin
            otok_nxt   = '{pt: e_r, cls: 1'b0};
            need_e_nxt = 1'b0;
            if (!need_cls_r) state_nxt = ST_IDLE;
          end else begin
            otok_nxt     = '{pt: '0, cls: 1'b1};
            need_cls_nxt = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      started_r  <= 1'b0;
      ovalid_r   <= 1'b0;
      need_x_r   <= 1'b0;
      need_e_r   <= 1'b0;
      need_cls_r <= 1'b0;
      first_r    <= '0;
      prev_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      started_r  <= started_nxt;
      ovalid_r   <= ovalid_nxt;
      need_x_r   <= need_x_nxt;
      need_e_r   <= need_e_nxt;
      need_cls_r <= need_cls_nxt;
      first_r    <= first_nxt;
      prev_r     <= prev_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    e_r    <= e_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    neg_r  <= neg_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    otok_r <= otok_nxt;
  end

endmodule

// ----- rtl/rpc_sink.sv -----
// ----------------------------------------------------------------------------
// rpc_sink: end of the chain
// Holds back the newest vertex one item so the final one can carry last,
// and turns a polygon with no vertices into a single empty item.
// ----------------------------------------------------------------------------
module rpc_sink (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rpc_pkg::tok_t in_tok,
  output logic          out_valid,
  input  logic          out_ready,
  output rpc_pkg::pt_t  out_pt,
  output logic          out_last,
  output logic          out_empty
);

  logic         seen_r, seen_nxt;
  rpc_pkg::pt_t held_r, held_nxt;
  logic         ovalid_r, ovalid_nxt;
  rpc_pkg::pt_t opt_r, opt_nxt;
  logic         olast_r, olast_nxt;
  logic         oempty_r, oempty_nxt;

  assign in_ready  = !ovalid_r || out_ready;
  assign out_valid = ovalid_r;
  assign out_pt    = opt_r;
  assign out_last  = olast_r;
  assign out_empty = oempty_r;

  always_comb begin
    seen_nxt   = seen_r;
    held_nxt   = held_r;
    ovalid_nxt = ovalid_r && !out_ready;
    opt_nxt    = opt_r;
    olast_nxt  = olast_r;
    oempty_nxt = oempty_r;
    if (in_valid && in_ready) begin
      if (in_tok.cls) begin
        ovalid_nxt = 1'b1;
        opt_nxt    = seen_r ? held_r : '0;
        olast_nxt  = 1'b1;
        oempty_nxt = !seen_r;
        seen_nxt   = 1'b0;
        held_nxt   = '0;
      end else begin
        if (seen_r) begin
          ovalid_nxt = 1'b1;
          opt_nxt    = held_r;
          olast_nxt  = 1'b0;
          oempty_nxt = 1'b0;
        end
        held_nxt = in_tok.pt;
        seen_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= 1'b0;
      held_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      seen_r   <= seen_nxt;
      held_r   <= held_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opt_r    <= opt_nxt;
    olast_r  <= olast_nxt;
    oempty_r <= oempty_nxt;
  end

endmodule

// ----- rtl/rect_polygon_clipper.sv -----
// ----------------------------------------------------------------------------
// rect_polygon_clipper: polygon clipping against an axis-aligned window
// Four clip cells (left, top, bottom, right) in a chain, then an output cell.
//
//   port     | direction | carries
//   in_ch    | sink      | vertex_x, vertex_y, vertex_last
//   out_ch   | source    | out_x, out_y, out_last, out_empty
//   cfg_*    | APB       | clip_x_min, clip_y_min, clip_x_max, clip_y_max
//
// The feeder takes a vertex item whenever its token slot is empty and adds a
// close token after a last vertex. A cell takes a new token only when idle;
// on a crossing it accepts, multiplies, runs 32 bit-serial divide steps and
// emits the crossing point, then the end vertex if inside and a close token
// if one was taken. Cells run concurrently, each on its own token. Reset
// clears the control state and valid flags and sets the window to its reset
// values. A stalled output backs up through the chain.
// ----------------------------------------------------------------------------
module rect_polygon_clipper (
  input  logic                    clk,
  input  logic                    rst_n,
  rpc_in_if.sink                  in_ch,
  rpc_out_if.source               out_ch,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [rpc_pkg::AW-1:0]  cfg_paddr,
  input  logic [rpc_pkg::DW-1:0]  cfg_pwdata,
  output logic [rpc_pkg::DW-1:0]  cfg_prdata,
  output logic                    cfg_pready
);

  rpc_pkg::coord_t x_min_r, y_min_r, x_max_r, y_max_r;
  logic [1:0]      reg_idx;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r <= '0;
      y_min_r <= '0;
      x_max_r <= {1'b0, {(rpc_pkg::CW-1){1'b1}}};
      y_max_r <= {1'b0, {(rpc_pkg::CW-1){1'b1}}};
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (reg_idx)
        rpc_pkg::REG_X_MIN: x_min_r <= cfg_pwdata[rpc_pkg::CW-1:0];
        rpc_pkg::REG_Y_MIN: y_min_r <= cfg_pwdata[rpc_pkg::CW-1:0];
        rpc_pkg::REG_X_MAX: x_max_r <= cfg_pwdata[rpc_pkg::CW-1:0];
        rpc_pkg::REG_Y_MAX: y_max_r <= cfg_pwdata[rpc_pkg::CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rpc_pkg::REG_X_MIN: cfg_prdata = rpc_pkg::DW'(x_min_r);
      rpc_pkg::REG_Y_MIN: cfg_prdata = rpc_pkg::DW'(y_min_r);
      rpc_pkg::REG_X_MAX: cfg_prdata = rpc_pkg::DW'(x_max_r);
      rpc_pkg::REG_Y_MAX: cfg_prdata = rpc_pkg::DW'(y_max_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // feeder: a vertex item becomes a vertex token, plus a close token if last
  logic          f_valid_r, f_pend_r;
  rpc_pkg::tok_t f_tok_r;
  logic          v  [0:4];
  logic          r  [0:4];
  rpc_pkg::tok_t t  [0:4];
  rpc_pkg::cell_cfg_t ccfg [0:3];

  assign in_ch.ready = !f_valid_r;
  assign v[0] = f_valid_r;
  assign t[0] = f_tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
      f_pend_r  <= 1'b0;
    end else if (!f_valid_r) begin
      if (in_ch.valid) begin
        f_valid_r <= 1'b1;
        f_pend_r  <= in_ch.vertex_last;
      end
    end else if (r[0]) begin
      f_valid_r <= f_pend_r;
      f_pend_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!f_valid_r) begin
      f_tok_r <= '{pt: '{x: in_ch.vertex_x, y: in_ch.vertex_y}, cls: 1'b0};
    end else if (r[0]) begin
      f_tok_r <= '{pt: '0, cls: 1'b1};
    end
  end

  // window edges: left, top, bottom, right
  assign ccfg[0] = '{axis_y: 1'b0, keep_gt: 1'b1, edge_v: x_min_r};
  assign ccfg[1] = '{axis_y: 1'b1, keep_gt: 1'b0, edge_v: y_max_r};
  assign ccfg[2] = '{axis_y: 1'b1, keep_gt: 1'b1, edge_v: y_min_r};
  assign ccfg[3] = '{axis_y: 1'b0, keep_gt: 1'b0, edge_v: x_max_r};

  for (genvar k = 0; k < 4; k++) begin : g_cell
    rpc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg       (ccfg[k]),
      .in_valid  (v[k]),
      .in_ready  (r[k]),
      .in_tok    (t[k]),
      .out_valid (v[k+1]),
      .out_ready (r[k+1]),
      .out_tok   (t[k+1])
    );
  end

  rpc_pkg::pt_t o_pt;

  rpc_sink u_sink (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v[4]),
    .in_ready  (r[4]),
    .in_tok    (t[4]),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_pt    (o_pt),
    .out_last  (out_ch.out_last),
    .out_empty (out_ch.out_empty)
  );

  assign out_ch.out_x = o_pt.x;
  assign out_ch.out_y = o_pt.y;

endmodule
